// ===== hdl/lpdc_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the light-level PID dimmer controller.
package lpdc_pkg;

   // Operation codes carried on the request selector.
   localparam logic [2:0] OP_TICK            = 3'd0;
   localparam logic [2:0] OP_STEP            = 3'd1;
   localparam logic [2:0] OP_MODE_BUTTON     = 3'd2;
   localparam logic [2:0] OP_SERIAL_SETPOINT = 3'd3;
   localparam logic [2:0] OP_SERIAL_MODE     = 3'd4;

   // Configuration register indexes.
   localparam logic [2:0] CSR_GAIN_P         = 3'd0;
   localparam logic [2:0] CSR_GAIN_I         = 3'd1;
   localparam logic [2:0] CSR_GAIN_D         = 3'd2;
   localparam logic [2:0] CSR_PWM_LIMIT      = 3'd3;
   localparam logic [2:0] CSR_LIMIT_ONE_LED  = 3'd4;
   localparam logic [2:0] CSR_LIMIT_TWO_LED  = 3'd5;
   localparam logic [2:0] CSR_SETPOINT_FLOOR = 3'd6;

   // Reset values of the configuration registers.
   localparam logic [15:0] GAIN_P_RST         = 16'd768;
   localparam logic [15:0] GAIN_I_RST         = 16'd384;
   localparam logic [15:0] GAIN_D_RST         = 16'd0;
   localparam logic [15:0] PWM_LIMIT_RST      = 16'd1000;
   localparam logic [11:0] LIMIT_ONE_LED_RST  = 12'd110;
   localparam logic [11:0] LIMIT_TWO_LED_RST  = 12'd180;
   localparam logic [11:0] SETPOINT_FLOOR_RST = 12'd2;

   // Reset values of the regulator state.
   localparam logic [11:0] SETPOINT_RST = 12'd2;

   // Datapath widths: error is Q.4 signed, accumulator is Q.12 signed.
   localparam int ERR_W  = 22;
   localparam int PROD_W = 41;
   localparam int SUM_W  = 50;
   localparam int ACC_W  = 48;

   // In-band threshold factor (percent).
   localparam logic [27:0] BAND_SCALE = 28'd100;

   // Configuration register bundle.
   typedef struct packed {
      logic [15:0] gain_p;
      logic [15:0] gain_i;
      logic [15:0] gain_d;
      logic [15:0] pwm_limit;
      logic [11:0] limit_one_led;
      logic [11:0] limit_two_led;
      logic [11:0] setpoint_floor;
   } cfg_type;

   // One request item.
   typedef struct packed {
      logic [2:0]  op;
      logic [19:0] lux_sample;
      logic        step_down;
      logic [11:0] serial_value;
      logic        serial_two;
   } req_item_type;

   // Fields produced by a tick.
   typedef struct packed {
      logic [15:0] pwm_first;
      logic [15:0] pwm_second;
      logic        in_band;
      logic [11:0] lux_report;
      logic        report_valid;
   } tick_out_type;

   // One response item.
   typedef struct packed {
      logic [15:0] pwm_first;
      logic [15:0] pwm_second;
      logic        in_band;
      logic [11:0] lux_report;
      logic        report_valid;
      logic [11:0] setpoint_now;
      logic        two_led_mode;
   } rsp_item_type;

   // Setpoint and mode state seen by the PID datapath.
   typedef struct packed {
      logic [11:0] setpoint;
      logic [11:0] upper_limit;
      logic        dual_mode;
   } sp_state_type;

endpackage

// ===== hdl/lpdc_csr.sv =====
`timescale 1ns / 1ps
// Configuration register file of the light-level PID dimmer controller.
module lpdc_csr (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_wr_en,
   input  logic [2:0]            csr_index,
   input  logic [15:0]           csr_wdata,
   output lpdc_pkg::cfg_type     cfg
);

   lpdc_pkg::cfg_type cfg_ff;
   lpdc_pkg::cfg_type cfg_in;

   // Decode the write index; unknown indexes are ignored.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         case (csr_index)
            lpdc_pkg::CSR_GAIN_P:         cfg_in.gain_p         = csr_wdata;
            lpdc_pkg::CSR_GAIN_I:         cfg_in.gain_i         = csr_wdata;
            lpdc_pkg::CSR_GAIN_D:         cfg_in.gain_d         = csr_wdata;
            lpdc_pkg::CSR_PWM_LIMIT:      cfg_in.pwm_limit      = csr_wdata;
            lpdc_pkg::CSR_LIMIT_ONE_LED:  cfg_in.limit_one_led  = csr_wdata[11:0];
            lpdc_pkg::CSR_LIMIT_TWO_LED:  cfg_in.limit_two_led  = csr_wdata[11:0];
            lpdc_pkg::CSR_SETPOINT_FLOOR: cfg_in.setpoint_floor = csr_wdata[11:0];
            default:                      cfg_in = cfg_ff;
         endcase
      end
   end

   // Register bank with reset defaults.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.gain_p         <= lpdc_pkg::GAIN_P_RST;
         cfg_ff.gain_i         <= lpdc_pkg::GAIN_I_RST;
         cfg_ff.gain_d         <= lpdc_pkg::GAIN_D_RST;
         cfg_ff.pwm_limit      <= lpdc_pkg::PWM_LIMIT_RST;
         cfg_ff.limit_one_led  <= lpdc_pkg::LIMIT_ONE_LED_RST;
         cfg_ff.limit_two_led  <= lpdc_pkg::LIMIT_TWO_LED_RST;
         cfg_ff.setpoint_floor <= lpdc_pkg::SETPOINT_FLOOR_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== hdl/lpdc_setpoint.sv =====
`timescale 1ns / 1ps
// Setpoint, encoder count, upper limit and LED mode state of the controller.
module lpdc_setpoint (
   input  logic                      clock,
   input  logic                      reset,
   input  lpdc_pkg::cfg_type         cfg,
   input  logic                      fire,
   input  lpdc_pkg::req_item_type    item,
   output lpdc_pkg::sp_state_type    state_now,
   output logic [11:0]               setpoint_next,
   output logic                      mode_next
);

   logic [11:0] setpoint_ff, setpoint_in;
   logic [11:0] count_ff, count_in;
   logic [11:0] upper_ff, upper_in;
   logic        mode_ff, mode_in;
   logic        go_two;

   // Next state for the request being retired.
   always_comb begin
      setpoint_in = setpoint_ff;
      count_in    = count_ff;
      upper_in    = upper_ff;
      mode_in     = mode_ff;
      go_two      = 1'b0;
      case (item.op)
         lpdc_pkg::OP_STEP: begin
            if (!item.step_down) begin
               count_in = (count_ff >= upper_ff) ? upper_ff : count_ff + 12'd1;
            end else begin
               count_in = (count_ff <= cfg.setpoint_floor) ? cfg.setpoint_floor
                                                           : count_ff - 12'd1;
            end
            setpoint_in = count_in;
         end
         lpdc_pkg::OP_MODE_BUTTON: begin
            go_two = !mode_ff;
            if (go_two) begin
               mode_in  = 1'b1;
               upper_in = cfg.limit_two_led;
            end else begin
               mode_in  = 1'b0;
               upper_in = cfg.limit_one_led;
               if (setpoint_ff > cfg.limit_one_led) begin
                  setpoint_in = cfg.limit_one_led;
               end
            end
         end
         lpdc_pkg::OP_SERIAL_SETPOINT: begin
            setpoint_in = item.serial_value;
            count_in    = item.serial_value;
         end
         lpdc_pkg::OP_SERIAL_MODE: begin
            go_two = item.serial_two;
            if (go_two) begin
               mode_in  = 1'b1;
               upper_in = cfg.limit_two_led;
            end else begin
               mode_in  = 1'b0;
               upper_in = cfg.limit_one_led;
               if (setpoint_ff > cfg.limit_one_led) begin
                  setpoint_in = cfg.limit_one_led;
               end
            end
         end
         default: begin
            setpoint_in = setpoint_ff;
         end
      endcase
   end

   // State registers, updated when a request retires.
   always_ff @(posedge clock) begin
      if (reset) begin
         setpoint_ff <= lpdc_pkg::SETPOINT_RST;
         count_ff    <= lpdc_pkg::SETPOINT_RST;
         upper_ff    <= lpdc_pkg::LIMIT_ONE_LED_RST;
         mode_ff     <= 1'b0;
      end else if (fire) begin
         setpoint_ff <= setpoint_in;
         count_ff    <= count_in;
         upper_ff    <= upper_in;
         mode_ff     <= mode_in;
      end
   end

   assign state_now.setpoint    = setpoint_ff;
   assign state_now.upper_limit = upper_ff;
   assign state_now.dual_mode   = mode_ff;
   assign setpoint_next         = setpoint_in;
   assign mode_next             = mode_in;

endmodule

// ===== hdl/lpdc_pid.sv =====
`timescale 1ns / 1ps
// Incremental PID step, PWM clamp and in-band check for a tick request.
module lpdc_pid (
   input  logic                      clock,
   input  logic                      reset,
   input  lpdc_pkg::cfg_type         cfg,
   input  logic                      fire,
   input  logic [19:0]               lux_sample,
   input  lpdc_pkg::sp_state_type    sp,
   output lpdc_pkg::tick_out_type    tick_out
);

   logic signed [lpdc_pkg::ERR_W-1:0]  err_prev_ff, err_prev2_ff;
   logic signed [lpdc_pkg::ACC_W-1:0]  acc_ff;
   logic signed [lpdc_pkg::ERR_W-1:0]  err_now;
   logic [17:0]                        coef0, coef1;
   logic signed [lpdc_pkg::PROD_W-1:0] prod0, prod1, prod2;
   logic signed [lpdc_pkg::SUM_W-1:0]  sum;
   logic signed [lpdc_pkg::ACC_W-1:0]  acc_sat;
   logic [34:0]                        acc_int;
   logic [15:0]                        pwm;
   logic [20:0]                        err_mag;
   logic [27:0]                        err_scaled;
   logic signed [12:0]                 span;
   logic                               band;

   // Error in Q.4: setpoint scaled by 16 minus the lux sample.
   assign err_now = $signed({6'b0, sp.setpoint, 4'b0}) - $signed({2'b0, lux_sample});

   // Incremental PID coefficients.
   assign coef0 = {2'b0, cfg.gain_p} + {2'b0, cfg.gain_i} + {2'b0, cfg.gain_d};
   assign coef1 = {2'b0, cfg.gain_p} + {1'b0, cfg.gain_d, 1'b0};

   // Three independent products.
   assign prod0 = $signed({1'b0, coef0}) * err_now;
   assign prod1 = $signed({1'b0, coef1}) * err_prev_ff;
   assign prod2 = $signed({1'b0, cfg.gain_d}) * err_prev2_ff;

   // Accumulate and saturate to the 48-bit signed range.
   assign sum = lpdc_pkg::SUM_W'(prod0) - lpdc_pkg::SUM_W'(prod1)
              + lpdc_pkg::SUM_W'(prod2) + lpdc_pkg::SUM_W'(acc_ff);

   always_comb begin
      if (sum[lpdc_pkg::SUM_W-1:lpdc_pkg::ACC_W-1] == '0 ||
          sum[lpdc_pkg::SUM_W-1:lpdc_pkg::ACC_W-1] == '1) begin
         acc_sat = sum[lpdc_pkg::ACC_W-1:0];
      end else if (sum[lpdc_pkg::SUM_W-1]) begin
         acc_sat = {1'b1, {(lpdc_pkg::ACC_W-1){1'b0}}};
      end else begin
         acc_sat = {1'b0, {(lpdc_pkg::ACC_W-1){1'b1}}};
      end
   end

   // PWM compare value: zero when negative, else integer part clamped to the limit.
   assign acc_int = acc_sat[lpdc_pkg::ACC_W-2:12];

   always_comb begin
      if (acc_sat[lpdc_pkg::ACC_W-1]) begin
         pwm = 16'd0;
      end else if (acc_int > {19'b0, cfg.pwm_limit}) begin
         pwm = cfg.pwm_limit;
      end else begin
         pwm = acc_int[15:0];
      end
   end

   // In-band check: |error| * 100 against the span in Q.4.
   assign err_mag    = err_now[lpdc_pkg::ERR_W-1] ? 21'(-err_now) : 21'(err_now);
   assign err_scaled = {7'b0, err_mag} * lpdc_pkg::BAND_SCALE;
   assign span       = $signed({1'b0, sp.upper_limit}) - $signed({1'b0, cfg.setpoint_floor});
   assign band       = !span[12] && (err_scaled <= {12'b0, span[11:0], 4'b0});

   // PID history, advanced on every retired tick.
   always_ff @(posedge clock) begin
      if (reset) begin
         err_prev_ff  <= '0;
         err_prev2_ff <= '0;
         acc_ff       <= '0;
      end else if (fire) begin
         err_prev_ff  <= err_now;
         err_prev2_ff <= err_prev_ff;
         acc_ff       <= acc_sat;
      end
   end

   assign tick_out.pwm_first    = sp.dual_mode ? pwm : 16'd0;
   assign tick_out.pwm_second   = pwm;
   assign tick_out.in_band      = band;
   assign tick_out.lux_report   = lux_sample[15:4];
   assign tick_out.report_valid = (lux_sample[19:16] == 4'd0);

endmodule

// ===== hdl/light_pid_dimmer_controller_top.sv =====
`timescale 1ns / 1ps
// Top level of the light-level PID dimmer controller.
//
//   Channel | Direction | Handshake           | Contents
//   req     | in        | req_tvalid/tready   | tuser: op; tdata: tick lux and command fields
//   rsp     | out       | rsp_tvalid/tready   | tdata: PWM values, flags, setpoint and mode
//   csr     | in        | csr_wr_en           | register index and 16-bit write data
//
// Each request is registered, processed by combinational logic (three products,
// one accumulate with saturation) and lands in the response register; one
// request per cycle sustained while the response is taken. Reset (synchronous,
// active high) restores the register defaults and clears the PID history. A
// stalled response holds; the input register still takes one more request behind it.
module light_pid_dimmer_controller_top (
   input  logic        clock,
   input  logic        reset,
   // tuser: op[2:0]
   // tdata: lux_sample[19:0], step_down[20], serial_value[32:21], serial_two[33], zero fill
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,
   input  logic [2:0]  req_tuser,
   // tdata: pwm_first[15:0], pwm_second[31:16], in_band[32], lux_report[44:33],
   //        report_valid[45], setpoint_now[57:46], two_led_mode[58], zero fill
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,
   input  logic        csr_wr_en,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_wdata
);

   lpdc_pkg::cfg_type      cfg;
   lpdc_pkg::req_item_type req_item;
   lpdc_pkg::req_item_type in_item_ff, in_item_in;
   lpdc_pkg::rsp_item_type rsp_item_ff, rsp_item_in;
   lpdc_pkg::sp_state_type sp_state;
   lpdc_pkg::tick_out_type tick_out;
   logic                   in_valid_ff, in_valid_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   advance, fire, tick_fire, req_accept;
   logic [11:0]            setpoint_next;
   logic                   mode_next;

   // Unpack the request.
   assign req_item.op           = req_tuser;
   assign req_item.lux_sample   = req_tdata[19:0];
   assign req_item.step_down    = req_tdata[20];
   assign req_item.serial_value = req_tdata[32:21];
   assign req_item.serial_two   = req_tdata[33];

   // Handshake: the input register drains whenever the response register can load.
   assign advance    = !rsp_valid_ff || rsp_tready;
   assign fire       = in_valid_ff && advance;
   assign tick_fire  = fire && (in_item_ff.op == lpdc_pkg::OP_TICK);
   assign req_tready = !in_valid_ff || advance;
   assign req_accept = req_tvalid && req_tready;

   lpdc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   lpdc_setpoint u_setpoint (
      .clock         (clock),
      .reset         (reset),
      .cfg           (cfg),
      .fire          (fire),
      .item          (in_item_ff),
      .state_now     (sp_state),
      .setpoint_next (setpoint_next),
      .mode_next     (mode_next)
   );

   lpdc_pid u_pid (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .fire       (tick_fire),
      .lux_sample (in_item_ff.lux_sample),
      .sp         (sp_state),
      .tick_out   (tick_out)
   );

   // Input register.
   always_comb begin
      in_valid_in = in_valid_ff;
      in_item_in  = in_item_ff;
      if (req_accept) begin
         in_valid_in = 1'b1;
         in_item_in  = req_item;
      end else if (fire) begin
         in_valid_in = 1'b0;
      end
   end

   // Response register: tick fields are zero for every other operation.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_item_in  = rsp_item_ff;
      if (fire) begin
         rsp_valid_in = 1'b1;
         if (in_item_ff.op == lpdc_pkg::OP_TICK) begin
            rsp_item_in.pwm_first    = tick_out.pwm_first;
            rsp_item_in.pwm_second   = tick_out.pwm_second;
            rsp_item_in.in_band      = tick_out.in_band;
            rsp_item_in.lux_report   = tick_out.lux_report;
            rsp_item_in.report_valid = tick_out.report_valid;
         end else begin
            rsp_item_in.pwm_first    = 16'd0;
            rsp_item_in.pwm_second   = 16'd0;
            rsp_item_in.in_band      = 1'b0;
            rsp_item_in.lux_report   = 12'd0;
            rsp_item_in.report_valid = 1'b0;
         end
         rsp_item_in.setpoint_now = setpoint_next;
         rsp_item_in.two_led_mode = mode_next;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      in_item_ff  <= in_item_in;
      rsp_item_ff <= rsp_item_in;
   end

   // Pack the response.
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'b0,
                        rsp_item_ff.two_led_mode,
                        rsp_item_ff.setpoint_now,
                        rsp_item_ff.report_valid,
                        rsp_item_ff.lux_report,
                        rsp_item_ff.in_band,
                        rsp_item_ff.pwm_second,
                        rsp_item_ff.pwm_first};

endmodule

// ===== bench/light_pid_dimmer_controller_top_test.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the light-level PID dimmer controller top level.
module light_pid_dimmer_controller_top_test;
   import lpdc_pkg::*;

   // Register index that decodes to no register.
   localparam logic [2:0] CSR_SPARE = 3'd7;
   // Range of operation codes that the block leaves without effect.
   localparam logic [2:0] OP_SPARE_LOW  = 3'd5;
   localparam logic [2:0] OP_SPARE_HIGH = 3'd7;
   localparam longint ACC_TOP    = (longint'(1) <<< 47) - 1;
   localparam longint ACC_BOTTOM = -ACC_TOP - 1;
   localparam int WATCHDOG_LIMIT = 1000;
   localparam int DRAIN_CYCLES   = 8;
   localparam int MAX_REPORTS    = 50;
   localparam int GAP_MAX        = 13;
   localparam int RANDOM_PHASES  = 6;
   localparam int PHASE_ITEMS    = 130;
   localparam int WINDUP_TICKS   = 60;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [39:0] req_tdata = '0;
   logic [2:0]  req_tuser = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [63:0] rsp_tdata;
   logic        csr_wr_en = 1'b0;
   logic [2:0]  csr_index = '0;
   logic [15:0] csr_wdata = '0;

   light_pid_dimmer_controller_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   // Free-running 2 ns clock.
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Mirror of the configuration registers and of the regulator state.
   cfg_type     cfg_mirror;
   logic [11:0] sp_level   = SETPOINT_RST;
   logic [11:0] enc_level  = SETPOINT_RST;
   logic [11:0] sp_ceiling = LIMIT_ONE_LED_RST;
   logic        dual_led   = 1'b0;
   longint      err_last   = 0;
   longint      err_older  = 0;
   longint      pid_sum    = 0;

   rsp_item_type dimmer_expect_q[$];
   rsp_item_type want_rsp;
   rsp_item_type seen_rsp;
   int           mismatch_count = 0;
   int           quiet_cycles = 0;
   int           req_gap_max = 0;
   int           rsp_gap_max = 0;

   function automatic cfg_type reset_settings();
      cfg_type c;
      c.gain_p         = GAIN_P_RST;
      c.gain_i         = GAIN_I_RST;
      c.gain_d         = GAIN_D_RST;
      c.pwm_limit      = PWM_LIMIT_RST;
      c.limit_one_led  = LIMIT_ONE_LED_RST;
      c.limit_two_led  = LIMIT_TWO_LED_RST;
      c.setpoint_floor = SETPOINT_FLOOR_RST;
      return c;
   endfunction

   // Mode changes: going to one LED lowers the setpoint to the new ceiling.
   function automatic void select_one_led();
      dual_led   = 1'b0;
      sp_ceiling = cfg_mirror.limit_one_led;
      if (sp_level > sp_ceiling) begin
         sp_level = sp_ceiling;
      end
   endfunction

   function automatic void select_two_led();
      dual_led   = 1'b1;
      sp_ceiling = cfg_mirror.limit_two_led;
   endfunction

   // Advances the mirrored regulator by one request and returns its response.
   function automatic rsp_item_type regulate_event(input req_item_type r);
      rsp_item_type o;
      longint       e0, a0, a1, a2, acc, mag, span, pwm;
      longint       sp_l, lux_l, kp, ki, kd, up_l, fl_l, lim_l;
      logic [15:0]  lux_int;
      o = '0;
      case (r.op)
         OP_TICK: begin
            sp_l  = sp_level;
            lux_l = r.lux_sample;
            kp    = cfg_mirror.gain_p;
            ki    = cfg_mirror.gain_i;
            kd    = cfg_mirror.gain_d;
            e0    = sp_l * 16 - lux_l;
            a0    = kp + ki + kd;
            a1    = kp + 2 * kd;
            a2    = kd;
            acc   = a0 * e0 - a1 * err_last + a2 * err_older + pid_sum;
            if (acc > ACC_TOP) begin
               acc = ACC_TOP;
            end
            if (acc < ACC_BOTTOM) begin
               acc = ACC_BOTTOM;
            end
            pid_sum   = acc;
            err_older = err_last;
            err_last  = e0;
            // Band test is signed, so a negative span never matches.
            mag  = (e0 < 0) ? -e0 : e0;
            up_l = sp_ceiling;
            fl_l = cfg_mirror.setpoint_floor;
            span = (up_l - fl_l) * 16;
            o.in_band      = (mag * 100 <= span);
            lux_int        = r.lux_sample[19:4];
            o.lux_report   = lux_int[11:0];
            o.report_valid = (lux_int <= 16'd4095);
            if (acc < 0) begin
               pwm = 0;
            end else begin
               pwm   = acc >>> 12;
               lim_l = cfg_mirror.pwm_limit;
               if (pwm > lim_l) begin
                  pwm = lim_l;
               end
            end
            o.pwm_second = pwm[15:0];
            o.pwm_first  = dual_led ? pwm[15:0] : 16'd0;
         end
         OP_STEP: begin
            if (!r.step_down) begin
               enc_level = (enc_level >= sp_ceiling) ? sp_ceiling : enc_level + 12'd1;
            end else begin
               enc_level = (enc_level <= cfg_mirror.setpoint_floor) ?
                           cfg_mirror.setpoint_floor : enc_level - 12'd1;
            end
            sp_level = enc_level;
         end
         OP_MODE_BUTTON: begin
            if (dual_led) begin
               select_one_led();
            end else begin
               select_two_led();
            end
         end
         OP_SERIAL_SETPOINT: begin
            sp_level  = r.serial_value;
            enc_level = r.serial_value;
         end
         OP_SERIAL_MODE: begin
            if (r.serial_two) begin
               select_two_led();
            end else begin
               select_one_led();
            end
         end
         default: begin
         end
      endcase
      o.setpoint_now = sp_level;
      o.two_led_mode = dual_led;
      return o;
   endfunction

   function automatic req_item_type make_item(input logic [2:0] op, input logic [19:0] lux,
                                              input logic down, input logic [11:0] sval,
                                              input logic two);
      req_item_type r;
      r.op           = op;
      r.lux_sample   = lux;
      r.step_down    = down;
      r.serial_value = sval;
      r.serial_two   = two;
      return r;
   endfunction

   // Random request: all fields random, op weighted toward ticks, values biased toward the limits.
   function automatic req_item_type random_request();
      req_item_type r;
      int           pick, t;
      r.step_down  = 1'($urandom);
      r.serial_two = 1'($urandom);
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
         r.op = OP_TICK;
      end else if (pick < 65) begin
         r.op = OP_STEP;
      end else if (pick < 73) begin
         r.op = OP_MODE_BUTTON;
      end else if (pick < 81) begin
         r.op = OP_SERIAL_SETPOINT;
      end else if (pick < 91) begin
         r.op = OP_SERIAL_MODE;
      end else begin
         r.op = 3'($urandom_range(OP_SPARE_LOW, OP_SPARE_HIGH));
      end
      case ($urandom_range(0, 3))
         0: r.lux_sample = 20'($urandom);
         1: begin
            t = int'($urandom_range(0, 64)) - 32 + int'(sp_level) * 16;
            r.lux_sample = (t < 0) ? 20'd0 : 20'(t);
         end
         2: r.lux_sample = 20'($urandom_range(65500, 65600));
         default: r.lux_sample = 20'($urandom_range(0, 4095));
      endcase
      case ($urandom_range(0, 3))
         0: r.serial_value = 12'($urandom);
         1: begin
            t = int'($urandom_range(0, 6)) - 3 + int'(sp_ceiling);
            r.serial_value = (t < 0) ? 12'd0 : ((t > 4095) ? 12'd4095 : 12'(t));
         end
         2: begin
            t = int'($urandom_range(0, 6)) - 3 + int'(cfg_mirror.setpoint_floor);
            r.serial_value = (t < 0) ? 12'd0 : ((t > 4095) ? 12'd4095 : 12'(t));
         end
         default: r.serial_value = 12'($urandom_range(0, 255));
      endcase
      return r;
   endfunction

   function automatic logic [15:0] random_gain();
      case ($urandom_range(0, 4))
         0: return 16'd0;
         1: return 16'hFFFF;
         2: return 16'($urandom_range(0, 255));
         3: return 16'($urandom_range(0, 1024));
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic logic [11:0] random_limit();
      case ($urandom_range(0, 4))
         0: return 12'd0;
         1: return 12'hFFF;
         2: return 12'($urandom_range(0, 300));
         default: return 12'($urandom);
      endcase
   endfunction

   function automatic cfg_type random_settings();
      cfg_type c;
      c.gain_p        = random_gain();
      c.gain_i        = random_gain();
      c.gain_d        = random_gain();
      c.pwm_limit     = ($urandom_range(0, 3) == 0) ? random_gain() : 16'($urandom_range(0, 4000));
      c.limit_one_led = random_limit();
      c.limit_two_led = random_limit();
      c.setpoint_floor = ($urandom_range(0, 3) == 0) ? random_limit() :
                         12'($urandom_range(0, 20));
      return c;
   endfunction

   task automatic report_mismatch(input string what);
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS) begin
         $display("mismatch at %0t: %s", $realtime, what);
      end
   endtask

   task automatic compare_field(input string name, input logic [15:0] got,
                                input logic [15:0] want);
      if (got !== want) begin
         report_mismatch($sformatf("%s got %0d, expected %0d", name, got, want));
      end
   endtask

   // Sends one request after a random gap and records its expected response.
   task automatic send_request(input req_item_type r);
      int gap;
      gap = $urandom_range(0, req_gap_max);
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tuser  <= r.op;
      req_tdata  <= {6'd0, r.serial_two, r.serial_value, r.step_down, r.lux_sample};
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      dimmer_expect_q.push_back(regulate_event(r));
   endtask

   // Holds off the sender until every outstanding response has been taken.
   task automatic wait_for_results();
      req_tvalid <= 1'b0;
      while (dimmer_expect_q.size() != 0) @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   // Writes every register while the block is idle, junk in the unused bits.
   task automatic apply_settings(input cfg_type c);
      logic [15:0] vals [0:CSR_SETPOINT_FLOOR];
      vals[CSR_GAIN_P]         = c.gain_p;
      vals[CSR_GAIN_I]         = c.gain_i;
      vals[CSR_GAIN_D]         = c.gain_d;
      vals[CSR_PWM_LIMIT]      = c.pwm_limit;
      vals[CSR_LIMIT_ONE_LED]  = {4'($urandom), c.limit_one_led};
      vals[CSR_LIMIT_TWO_LED]  = {4'($urandom), c.limit_two_led};
      vals[CSR_SETPOINT_FLOOR] = {4'($urandom), c.setpoint_floor};
      wait_for_results();
      for (int i = 0; i <= CSR_SETPOINT_FLOOR; i++) begin
         csr_wr_en <= 1'b1;
         csr_index <= 3'(i);
         csr_wdata <= vals[i];
         @(posedge clock);
      end
      // A write to the spare index must change nothing.
      csr_wr_en <= 1'b1;
      csr_index <= CSR_SPARE;
      csr_wdata <= 16'($urandom);
      @(posedge clock);
      csr_wr_en  <= 1'b0;
      cfg_mirror = c;
   endtask

   // Ticks straight out of reset: error signs, zero error and report range edges.
   task automatic test_power_on_defaults();
      send_request(make_item(OP_TICK, 20'd0, 1'b0, 12'd0, 1'b0));
      send_request(make_item(OP_TICK, 20'd32, 1'b1, 12'hFFF, 1'b1));
      send_request(make_item(OP_TICK, 20'hFFFFF, 1'b0, 12'd0, 1'b0));
      send_request(make_item(OP_TICK, 20'h0FFF0, 1'b0, 12'd0, 1'b0));
      send_request(make_item(OP_TICK, 20'h10000, 1'b0, 12'd0, 1'b0));
   endtask

   // Encoder saturation at floor and ceiling, and unclamped serial setpoints.
   task automatic test_encoder_and_setpoint();
      send_request(make_item(OP_STEP, 20'd0, 1'b1, 12'd0, 1'b0));
      send_request(make_item(OP_SERIAL_SETPOINT, 20'd0, 1'b0, 12'd109, 1'b0));
      send_request(make_item(OP_STEP, 20'd0, 1'b0, 12'd0, 1'b0));
      send_request(make_item(OP_STEP, 20'd0, 1'b0, 12'd0, 1'b0));
      send_request(make_item(OP_SERIAL_SETPOINT, 20'd0, 1'b0, 12'hFFF, 1'b0));
      send_request(make_item(OP_STEP, 20'd0, 1'b0, 12'd0, 1'b0));
      send_request(make_item(OP_SERIAL_SETPOINT, 20'd0, 1'b0, 12'd0, 1'b0));
      send_request(make_item(OP_STEP, 20'd0, 1'b1, 12'd0, 1'b0));
   endtask

   // Button and serial mode changes, channel 1 output, and ignored op codes.
   task automatic test_led_modes();
      send_request(make_item(OP_MODE_BUTTON, 20'd0, 1'b0, 12'd0, 1'b0));
      send_request(make_item(OP_SERIAL_SETPOINT, 20'd0, 1'b0, 12'd150, 1'b0));
      send_request(make_item(OP_TICK, 20'd0, 1'b0, 12'd0, 1'b0));
      send_request(make_item(OP_SERIAL_MODE, 20'd0, 1'b0, 12'd0, 1'b0));
      send_request(make_item(OP_SERIAL_MODE, 20'd0, 1'b0, 12'd0, 1'b1));
      send_request(make_item(OP_MODE_BUTTON, 20'd0, 1'b0, 12'd0, 1'b0));
      send_request(make_item(OP_SPARE_HIGH, 20'hFFFFF, 1'b1, 12'hFFF, 1'b1));
   endtask

   // Register extremes: negative span, zero span, zero and full PWM clamp.
   task automatic test_register_extremes();
      cfg_type c;
      c = '{gain_p: 16'hFFFF, gain_i: 16'hFFFF, gain_d: 16'hFFFF, pwm_limit: 16'd0,
            limit_one_led: 12'd0, limit_two_led: 12'hFFF, setpoint_floor: 12'hFFF};
      apply_settings(c);
      send_request(make_item(OP_SERIAL_MODE, 20'd0, 1'b0, 12'd0, 1'b0));
      send_request(make_item(OP_TICK, 20'd0, 1'b0, 12'd0, 1'b0));
      send_request(make_item(OP_TICK, 20'hFFFFF, 1'b0, 12'd0, 1'b0));
      c = '{gain_p: 16'd0, gain_i: 16'd0, gain_d: 16'd0, pwm_limit: 16'hFFFF,
            limit_one_led: 12'd0, limit_two_led: 12'hFFF, setpoint_floor: 12'd0};
      apply_settings(c);
      send_request(make_item(OP_TICK, 20'd0, 1'b0, 12'd0, 1'b0));
      send_request(make_item(OP_SERIAL_MODE, 20'd0, 1'b0, 12'd0, 1'b1));
      send_request(make_item(OP_TICK, 20'd5, 1'b0, 12'd0, 1'b0));
   endtask

   // Random traffic in phases, each with its own settings and idling pattern.
   task automatic test_random_traffic();
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         req_gap_max = (phase == 0 || phase == 2) ? 0 : GAP_MAX;
         rsp_gap_max = (phase == 0 || phase == 1) ? 0 : GAP_MAX;
         apply_settings((phase == 0) ? reset_settings() : random_settings());
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            // Halfway through, let every outstanding response drain.
            if (n == PHASE_ITEMS / 2) begin
               wait_for_results();
            end
            send_request(random_request());
         end
      end
   endtask

   // Drives the accumulator far negative and works around it.
   task automatic test_accumulator_windup();
      cfg_type c;
      c = reset_settings();
      c.gain_p    = 16'd0;
      c.gain_i    = 16'hFFFF;
      c.gain_d    = 16'd0;
      c.pwm_limit = 16'hFFFF;
      req_gap_max = 0;
      rsp_gap_max = 0;
      apply_settings(c);
      for (int n = 0; n < WINDUP_TICKS; n++) begin
         send_request(make_item(OP_TICK, 20'hFFFFF, 1'b0, 12'd0, 1'b0));
      end
      req_gap_max = GAP_MAX;
      rsp_gap_max = GAP_MAX;
      for (int n = 0; n < 30; n++) begin
         send_request(random_request());
      end
   endtask

   // Response side: random stall before each response is taken.
   initial begin
      int gap;
      forever begin
         @(posedge clock);
         gap = $urandom_range(0, rsp_gap_max);
         if (gap != 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         while (!(rsp_tvalid && rsp_tready)) @(posedge clock);
      end
   end

   // Compares each accepted response with the oldest expected one.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         seen_rsp.pwm_first    = rsp_tdata[15:0];
         seen_rsp.pwm_second   = rsp_tdata[31:16];
         seen_rsp.in_band      = rsp_tdata[32];
         seen_rsp.lux_report   = rsp_tdata[44:33];
         seen_rsp.report_valid = rsp_tdata[45];
         seen_rsp.setpoint_now = rsp_tdata[57:46];
         seen_rsp.two_led_mode = rsp_tdata[58];
         if (dimmer_expect_q.size() == 0) begin
            report_mismatch("response arrived with no request outstanding");
         end else begin
            want_rsp = dimmer_expect_q.pop_front();
            compare_field("pwm_first", seen_rsp.pwm_first, want_rsp.pwm_first);
            compare_field("pwm_second", seen_rsp.pwm_second, want_rsp.pwm_second);
            compare_field("in_band", 16'(seen_rsp.in_band), 16'(want_rsp.in_band));
            compare_field("lux_report", 16'(seen_rsp.lux_report), 16'(want_rsp.lux_report));
            compare_field("report_valid", 16'(seen_rsp.report_valid),
                          16'(want_rsp.report_valid));
            compare_field("setpoint_now", 16'(seen_rsp.setpoint_now),
                          16'(want_rsp.setpoint_now));
            compare_field("two_led_mode", 16'(seen_rsp.two_led_mode),
                          16'(want_rsp.two_led_mode));
         end
      end
   end

   // Watchdog: ends the run when no request or response moves for too long.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("status: fail");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Test sequence.
   initial begin
      cfg_mirror = reset_settings();
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      test_power_on_defaults();
      test_encoder_and_setpoint();
      test_led_modes();
      test_register_extremes();
      test_random_traffic();
      test_accumulator_windup();
      wait_for_results();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (dimmer_expect_q.size() != 0) begin
         report_mismatch("requests left without a response");
      end
      if (mismatch_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
